// ----- rtl/vrt_pkg.sv -----
// ---------------------------------------------------------------------------
// vrt_pkg : shared types and constants for the voxel ray traversal block
// Result codes, request codes and the controller/datapath command words.
// ---------------------------------------------------------------------------
package vrt_pkg;

   localparam int FRAC_BITS_DEF  = 16;
   localparam int VOXEL_BITS_DEF = 16;
   localparam int DIR_FRAC       = 14;
   localparam logic [7:0] RANGE_RESET = 8'd10;

   localparam logic KIND_START = 1'b0;
   localparam logic KIND_REPLY = 1'b1;

   localparam logic [1:0] RK_QUERY = 2'd0;
   localparam logic [1:0] RK_HIT   = 2'd1;
   localparam logic [1:0] RK_MISS  = 2'd2;

   localparam logic SEL_INC = 1'b0;
   localparam logic SEL_BND = 1'b1;

   typedef struct packed {
      logic       start;
      logic       reply;
      logic       div_load;
      logic       div_step;
      logic       div_store;
      logic [1:0] axis;
      logic       sel;
   } cmd_type;

   typedef struct packed {
      logic active;
      logic div_last;
   } status_type;

endpackage

// ----- rtl/vrt_dp.sv -----
// ---------------------------------------------------------------------------
// vrt_dp : ray state, serial divider and step logic
// Holds the per-axis ray state, runs the restoring divider and the step.
// ---------------------------------------------------------------------------
module vrt_dp #(
   parameter int FRAC_BITS  = vrt_pkg::FRAC_BITS_DEF,
   parameter int VOXEL_BITS = vrt_pkg::VOXEL_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [7:0]           csr_wr_data,
   input  logic                 req_occupied,
   input  logic signed [31:0]   req_origin_x,
   input  logic signed [31:0]   req_origin_y,
   input  logic signed [31:0]   req_origin_z,
   input  logic signed [15:0]   req_dir_x,
   input  logic signed [15:0]   req_dir_y,
   input  logic signed [15:0]   req_dir_z,
   input  vrt_pkg::cmd_type     cmd,
   output vrt_pkg::status_type  status,
   output logic [1:0]           rsp_result_kind,
   output logic signed [15:0]   rsp_voxel_x,
   output logic signed [15:0]   rsp_voxel_y,
   output logic signed [15:0]   rsp_voxel_z,
   output logic signed [15:0]   rsp_entry_x,
   output logic signed [15:0]   rsp_entry_y,
   output logic signed [15:0]   rsp_entry_z
);
   import vrt_pkg::*;

   localparam int DW = FRAC_BITS + DIR_FRAC + 1;
   localparam int CW = $clog2(DW);
   localparam int VB = VOXEL_BITS;

   logic [7:0]            range_ff, range_in;
   logic                  active_ff, active_in;
   logic [FRAC_BITS-1:0]  frac_ff [3], frac_in [3];
   logic [16:0]           mag_ff [3], mag_in [3];
   logic                  neg_ff [3], neg_in [3];
   logic [VB-1:0]         cur_ff [3], cur_in [3];
   logic [VB-1:0]         prev_ff [3], prev_in [3];
   logic [31:0]           bnd_ff [3], bnd_in [3];
   logic [31:0]           inc_ff [3], inc_in [3];
   logic [31:0]           trav_ff, trav_in;
   logic [16:0]           rem_ff, rem_in;
   logic [DW-1:0]         dvd_ff, dvd_in;
   logic [DW-1:0]         quo_ff, quo_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic [1:0]            okind_ff, okind_in;
   logic [15:0]           ovox_ff [3], ovox_in [3];
   logic [15:0]           oent_ff [3], oent_in [3];

   logic [31:0]           origin [3];
   logic [15:0]           dir [3];
   logic [31:0]           range_lim;
   logic [17:0]           trial;
   logic [1:0]            pick;
   logic [FRAC_BITS:0]    num;
   logic [31:0]           result;

   function automatic logic [VB-1:0] floor_vox(input logic [31:0] o);
      logic signed [63:0] e;
      e = 64'(signed'(o));
      e = e >>> FRAC_BITS;
      return e[VB-1:0];
   endfunction

   function automatic logic [16:0] mag_of(input logic [15:0] d);
      return d[15] ? (17'h10000 - {1'b0, d}) : {1'b0, d};
   endfunction

   function automatic logic [31:0] sat_quo(input logic [DW-1:0] q);
      logic [DW+31:0] w;
      w = (DW+32)'(q);
      return (w[DW+31:32] != '0) ? 32'hFFFF_FFFF : w[31:0];
   endfunction

   function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
   endfunction

   function automatic logic [15:0] out16(input logic [VB-1:0] v);
      logic [VB+15:0] w;
      w = (VB+16)'(v);
      return w[15:0];
   endfunction

   assign origin[0] = req_origin_x;
   assign origin[1] = req_origin_y;
   assign origin[2] = req_origin_z;
   assign dir[0]    = req_dir_x;
   assign dir[1]    = req_dir_y;
   assign dir[2]    = req_dir_z;

   assign range_lim = 32'(range_ff) << FRAC_BITS;
   assign trial     = {rem_ff, dvd_ff[DW-1]};
   assign pick      = (bnd_ff[0] < bnd_ff[1]) ? ((bnd_ff[0] < bnd_ff[2]) ? 2'd0 : 2'd2)
                                              : ((bnd_ff[1] < bnd_ff[2]) ? 2'd1 : 2'd2);
   assign num       = neg_ff[cmd.axis] ? {1'b0, frac_ff[cmd.axis]}
                                       : ((FRAC_BITS+1)'(1) << FRAC_BITS) -
                                         {1'b0, frac_ff[cmd.axis]};
   assign result    = (mag_ff[cmd.axis] == '0) ? range_lim : sat_quo(quo_ff);

   always_comb begin
      range_in  = csr_wr_en ? csr_wr_data : range_ff;
      active_in = active_ff;
      trav_in   = trav_ff;
      rem_in    = rem_ff;
      dvd_in    = dvd_ff;
      quo_in    = quo_ff;
      cnt_in    = cnt_ff;
      okind_in  = okind_ff;
      for (int i = 0; i < 3; i++) begin
         frac_in[i] = frac_ff[i];
         mag_in[i]  = mag_ff[i];
         neg_in[i]  = neg_ff[i];
         cur_in[i]  = cur_ff[i];
         prev_in[i] = prev_ff[i];
         bnd_in[i]  = bnd_ff[i];
         inc_in[i]  = inc_ff[i];
         ovox_in[i] = ovox_ff[i];
         oent_in[i] = oent_ff[i];
      end

      if (cmd.start) begin
         active_in = 1'b1;
         trav_in   = '0;
         okind_in  = RK_QUERY;
         for (int i = 0; i < 3; i++) begin
            frac_in[i] = origin[i][FRAC_BITS-1:0];
            mag_in[i]  = mag_of(dir[i]);
            neg_in[i]  = dir[i][15];
            cur_in[i]  = floor_vox(origin[i]);
            prev_in[i] = floor_vox(origin[i]);
            ovox_in[i] = out16(floor_vox(origin[i]));
            oent_in[i] = '0;
         end
      end

      if (cmd.reply) begin
         if (req_occupied) begin
            active_in = 1'b0;
            okind_in  = RK_HIT;
            for (int i = 0; i < 3; i++) begin
               ovox_in[i] = out16(cur_ff[i]);
               oent_in[i] = out16(prev_ff[i]);
            end
         end else if (trav_ff >= range_lim) begin
            active_in = 1'b0;
            okind_in  = RK_MISS;
            for (int i = 0; i < 3; i++) begin
               ovox_in[i] = '0;
               oent_in[i] = '0;
            end
         end else begin
            okind_in    = RK_QUERY;
            trav_in     = bnd_ff[pick];
            bnd_in[pick] = sat_add(bnd_ff[pick], inc_ff[pick]);
            for (int i = 0; i < 3; i++) begin
               prev_in[i] = cur_ff[i];
               if (2'(i) == pick) begin
                  cur_in[i] = neg_ff[i] ? cur_ff[i] - VB'(1) : cur_ff[i] + VB'(1);
               end
               ovox_in[i] = out16(cur_in[i]);
               oent_in[i] = '0;
            end
         end
      end

      // load dividend: increment uses 2^(F+14), boundary uses num * 2^14
      if (cmd.div_load) begin
         rem_in = '0;
         quo_in = '0;
         cnt_in = CW'(DW - 1);
         if (cmd.sel == SEL_INC) begin
            dvd_in = DW'(1) << (FRAC_BITS + DIR_FRAC);
         end else begin
            dvd_in = DW'(num) << DIR_FRAC;
         end
      end

      if (cmd.div_step) begin
         dvd_in = dvd_ff << 1;
         cnt_in = cnt_ff - CW'(1);
         if (trial >= {1'b0, mag_ff[cmd.axis]}) begin
            rem_in = 17'(trial - {1'b0, mag_ff[cmd.axis]});
            quo_in = {quo_ff[DW-2:0], 1'b1};
         end else begin
            rem_in = trial[16:0];
            quo_in = {quo_ff[DW-2:0], 1'b0};
         end
      end

      if (cmd.div_store) begin
         if (cmd.sel == SEL_INC) begin
            inc_in[cmd.axis] = result;
         end else begin
            bnd_in[cmd.axis] = result;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         range_ff  <= RANGE_RESET;
         active_ff <= 1'b0;
         trav_ff   <= '0;
         for (int i = 0; i < 3; i++) begin
            cur_ff[i]  <= '0;
            prev_ff[i] <= '0;
            neg_ff[i]  <= 1'b0;
            bnd_ff[i]  <= '0;
            inc_ff[i]  <= '0;
         end
      end else begin
         range_ff  <= range_in;
         active_ff <= active_in;
         trav_ff   <= trav_in;
         for (int i = 0; i < 3; i++) begin
            cur_ff[i]  <= cur_in[i];
            prev_ff[i] <= prev_in[i];
            neg_ff[i]  <= neg_in[i];
            bnd_ff[i]  <= bnd_in[i];
            inc_ff[i]  <= inc_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff   <= rem_in;
      dvd_ff   <= dvd_in;
      quo_ff   <= quo_in;
      cnt_ff   <= cnt_in;
      okind_ff <= okind_in;
      for (int i = 0; i < 3; i++) begin
         frac_ff[i] <= frac_in[i];
         mag_ff[i]  <= mag_in[i];
         ovox_ff[i] <= ovox_in[i];
         oent_ff[i] <= oent_in[i];
      end
   end

   assign status.active   = active_ff;
   assign status.div_last = (cnt_ff == '0);

   assign rsp_result_kind = okind_ff;
   assign rsp_voxel_x     = ovox_ff[0];
   assign rsp_voxel_y     = ovox_ff[1];
   assign rsp_voxel_z     = ovox_ff[2];
   assign rsp_entry_x     = oent_ff[0];
   assign rsp_entry_y     = oent_ff[1];
   assign rsp_entry_z     = oent_ff[2];

endmodule

// ----- rtl/vrt_ctrl.sv -----
// ---------------------------------------------------------------------------
// vrt_ctrl : sequencer for the voxel ray traversal block
// Takes words, walks the six setup divisions and holds the result word.
// ---------------------------------------------------------------------------
module vrt_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_kind,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  vrt_pkg::status_type  status,
   output vrt_pkg::cmd_type     cmd
);
   import vrt_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_DLOAD  = 3'd1;
   localparam logic [2:0] S_DRUN   = 3'd2;
   localparam logic [2:0] S_DSTORE = 3'd3;
   localparam logic [2:0] S_OUT    = 3'd4;

   logic [2:0] state_ff, state_in;
   logic [1:0] axis_ff, axis_in;
   logic       sel_ff, sel_in;
   logic       accept;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in      = state_ff;
      axis_in       = axis_ff;
      sel_in        = sel_ff;
      cmd           = '0;
      cmd.axis      = axis_ff;
      cmd.sel       = sel_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_kind == KIND_START) begin
                  cmd.start = 1'b1;
                  axis_in   = 2'd0;
                  sel_in    = SEL_INC;
                  state_in  = S_DLOAD;
               end else if (status.active) begin
                  cmd.reply = 1'b1;
                  state_in  = S_OUT;
               end
            end
         end
         S_DLOAD: begin
            cmd.div_load = 1'b1;
            state_in     = S_DRUN;
         end
         S_DRUN: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = S_DSTORE;
            end
         end
         S_DSTORE: begin
            cmd.div_store = 1'b1;
            if (axis_ff == 2'd2 && sel_ff == SEL_BND) begin
               state_in = S_OUT;
            end else begin
               sel_in   = ~sel_ff;
               axis_in  = (sel_ff == SEL_BND) ? axis_ff + 2'd1 : axis_ff;
               state_in = S_DLOAD;
            end
         end
         S_OUT: begin
            if (!rsp_stall) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         axis_ff  <= 2'd0;
         sel_ff   <= SEL_INC;
      end else begin
         state_ff <= state_in;
         axis_ff  <= axis_in;
         sel_ff   <= sel_in;
      end
   end

   a_last_store_to_out: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DSTORE && axis_ff == 2'd2 && sel_ff == SEL_BND) |=> rsp_valid)
      else $error("final division store did not raise the result word");

   a_no_axis_three: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DLOAD || state_ff == S_DRUN || state_ff == S_DSTORE) |-> axis_ff != 2'd3)
      else $error("division sequencer ran past the z axis");

   a_out_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> ($past(state_ff) == S_DSTORE || $past(state_ff) == S_IDLE))
      else $error("result word raised from an unexpected state");

endmodule

// ----- rtl/voxel_ray_traversal.sv -----
// ---------------------------------------------------------------------------
// voxel_ray_traversal : 3D DDA voxel walk in fixed point
// A start word sets up a ray and queries the origin voxel; each occupancy
// reply gives a hit, a miss or a step to the next voxel and its query.
// ---------------------------------------------------------------------------
// Reply word: accepted, then the result word is held until taken.
// Start word: runs the six setup divisions on the single radix-2 divider,
//   one quotient bit a cycle, shared by the increment and boundary
//   divisions of all three axes.
// One word is in flight at a time; a reply with no ray active yields no result.
// Reset (synchronous, active high) clears the ray and loads view_range = 10.
// ---------------------------------------------------------------------------
module voxel_ray_traversal #(
   parameter int FRAC_BITS  = vrt_pkg::FRAC_BITS_DEF,
   parameter int VOXEL_BITS = vrt_pkg::VOXEL_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic [7:0]          csr_wr_data,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_kind,
   input  logic signed [31:0]  req_origin_x,
   input  logic signed [31:0]  req_origin_y,
   input  logic signed [31:0]  req_origin_z,
   input  logic signed [15:0]  req_dir_x,
   input  logic signed [15:0]  req_dir_y,
   input  logic signed [15:0]  req_dir_z,
   input  logic                req_occupied,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [1:0]          rsp_result_kind,
   output logic signed [15:0]  rsp_voxel_x,
   output logic signed [15:0]  rsp_voxel_y,
   output logic signed [15:0]  rsp_voxel_z,
   output logic signed [15:0]  rsp_entry_x,
   output logic signed [15:0]  rsp_entry_y,
   output logic signed [15:0]  rsp_entry_z
);
   import vrt_pkg::*;

   // command word from the sequencer, status back from the datapath
   cmd_type    cmd;
   status_type status;

   // sequencer: handshakes and the order of the setup divisions
   vrt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_kind  (req_kind),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: ray state, divider, axis choice and the result word register
   vrt_dp #(
      .FRAC_BITS  (FRAC_BITS),
      .VOXEL_BITS (VOXEL_BITS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .req_occupied    (req_occupied),
      .req_origin_x    (req_origin_x),
      .req_origin_y    (req_origin_y),
      .req_origin_z    (req_origin_z),
      .req_dir_x       (req_dir_x),
      .req_dir_y       (req_dir_y),
      .req_dir_z       (req_dir_z),
      .cmd             (cmd),
      .status          (status),
      .rsp_result_kind (rsp_result_kind),
      .rsp_voxel_x     (rsp_voxel_x),
      .rsp_voxel_y     (rsp_voxel_y),
      .rsp_voxel_z     (rsp_voxel_z),
      .rsp_entry_x     (rsp_entry_x),
      .rsp_entry_y     (rsp_entry_y),
      .rsp_entry_z     (rsp_entry_z)
   );

endmodule
